@@ sv/wsed_pkg.sv @@
package wsed_pkg;

  localparam int MAX_WORDS_DEF  = 64;
  localparam int TOKEN_BITS_DEF = 32;
  localparam int TOKEN_W        = 32;
  localparam int DIST_W         = 8;
  localparam int QUEUE_DEPTH    = 2;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_COMPUTE     = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [TOKEN_W-1:0] token;
  } req_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     overflow;
  } res_t;

  // Classified request, queued between front and back
  typedef struct packed {
    req_e               op;
    logic [TOKEN_W-1:0] token;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } work_chan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_FINISH
  } back_state_e;

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [31:0] v);
    logic signed [DIST_W-1:0] r;
    if (v > 32'sd127) begin
      r = 8'sd127;
    end else if (v < -32'sd128) begin
      r = -8'sd128;
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/wsed_ram.sv @@
module wsed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/wsed_front.sv @@
module wsed_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  wsed_pkg::req_t      req_data,
  output wsed_pkg::work_chan_t chan,
  input  logic                pop
);

  localparam int PTR_W = (wsed_pkg::QUEUE_DEPTH > 1) ? $clog2(wsed_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(wsed_pkg::QUEUE_DEPTH + 1);

  wsed_pkg::work_t q [wsed_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic            keep;
  logic            push;
  wsed_pkg::req_e  op;

  // Classify; unused code is dropped here and never reaches the back end
  always_comb begin
    keep = 1'b0;
    op   = wsed_pkg::REQ_LOAD_FIRST;
    unique case (req_data.req_type)
      wsed_pkg::REQ_LOAD_FIRST: begin
        keep = 1'b1;
        op   = wsed_pkg::REQ_LOAD_FIRST;
      end
      wsed_pkg::REQ_LOAD_SECOND: begin
        keep = 1'b1;
        op   = wsed_pkg::REQ_LOAD_SECOND;
      end
      wsed_pkg::REQ_COMPUTE: begin
        keep = 1'b1;
        op   = wsed_pkg::REQ_COMPUTE;
      end
      default: keep = 1'b0;
    endcase
  end

  assign req_stall  = (count == CNT_W'(wsed_pkg::QUEUE_DEPTH));
  assign push       = req_valid && !req_stall && keep;
  assign chan.valid = (count != '0);
  assign chan.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(wsed_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(wsed_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op, token: req_data.token};
    end
  end

endmodule

@@ sv/wsed_back.sv @@
module wsed_back #(
  parameter int MAX_WORDS  = wsed_pkg::MAX_WORDS_DEF,
  parameter int TOKEN_BITS = wsed_pkg::TOKEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsed_pkg::work_chan_t chan,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output wsed_pkg::res_t       res_data
);

  localparam int LEN_W  = $clog2(MAX_WORDS + 1);
  localparam int AW     = $clog2(MAX_WORDS);
  localparam int WORD_W = (TOKEN_BITS < wsed_pkg::TOKEN_W) ? TOKEN_BITS : wsed_pkg::TOKEN_W;

  wsed_pkg::back_state_e state, state_next;

  logic [LEN_W-1:0] len_a, len_a_next, len_b, len_b_next;
  logic             dropped, dropped_next;
  logic             res_valid_next;
  wsed_pkg::res_t   res_data_next;

  logic [LEN_W-1:0] row_i, row_i_next, col_j, col_j_next;
  logic [LEN_W-1:0] left, left_next, diag, diag_next;
  logic signed [wsed_pkg::DIST_W-1:0] score, score_next;

  logic              a_we, a_re, b_we, b_re, c_we, c_re;
  logic [AW-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
  logic [LEN_W-1:0]  c_waddr, c_raddr, c_wdata;
  logic [WORD_W-1:0] a_rd, b_rd, tok;
  logic [LEN_W-1:0]  cost_rd;

  // Cell datapath
  logic [LEN_W-1:0]        above, row_m1, cell_cost;
  logic                    sub;
  logic [LEN_W:0]          up1, left1, diag1, m01, m012;
  logic signed [LEN_W+1:0] adj;
  logic signed [31:0]      adj_w, empty_w;

  assign tok    = chan.item.token[WORD_W-1:0];
  assign row_m1 = row_i - 1'b1;
  // First row reads the implicit initial row 0..n2
  assign above  = (row_i == LEN_W'(1)) ? col_j : cost_rd;
  assign sub    = (a_rd != b_rd);
  assign up1    = {1'b0, above} + 1'b1;
  assign left1  = {1'b0, left} + 1'b1;
  assign diag1  = {1'b0, diag} + (LEN_W+1)'(sub);
  assign m01    = (up1 < left1) ? up1 : left1;
  assign m012   = (m01 < diag1) ? m01 : diag1;
  assign cell_cost = m012[LEN_W-1:0];

  assign adj     = $signed({2'b00, cell_cost}) - $signed({2'b00, len_a})
                   - $signed({2'b00, len_b});
  assign adj_w   = 32'(adj);
  assign empty_w = $signed(32'((len_a == '0) ? len_b : len_a));

  wsed_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_first_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (tok),
    .rd_en   (a_re),
    .rd_addr (a_raddr),
    .rd_data (a_rd)
  );

  wsed_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_second_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (tok),
    .rd_en   (b_re),
    .rd_addr (b_raddr),
    .rd_data (b_rd)
  );

  wsed_ram #(.WIDTH(LEN_W), .DEPTH(MAX_WORDS + 1)) u_cost_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_en   (c_re),
    .rd_addr (c_raddr),
    .rd_data (cost_rd)
  );

  always_comb begin
    state_next     = state;
    len_a_next     = len_a;
    len_b_next     = len_b;
    dropped_next   = dropped;
    row_i_next     = row_i;
    col_j_next     = col_j;
    left_next      = left;
    diag_next      = diag;
    score_next     = score;
    res_valid_next = res_valid;
    res_data_next  = res_data;
    pop     = 1'b0;
    a_we    = 1'b0;
    a_re    = 1'b0;
    b_we    = 1'b0;
    b_re    = 1'b0;
    c_we    = 1'b0;
    c_re    = 1'b0;
    a_waddr = len_a[AW-1:0];
    b_waddr = len_b[AW-1:0];
    a_raddr = row_m1[AW-1:0];
    b_raddr = '0;
    c_raddr = LEN_W'(1);
    c_waddr = col_j;
    c_wdata = cell_cost;

    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    unique case (state)
      wsed_pkg::ST_IDLE: begin
        if (chan.valid) begin
          pop = 1'b1;
          unique case (chan.item.op)
            wsed_pkg::REQ_LOAD_FIRST: begin
              if (len_a < LEN_W'(MAX_WORDS)) begin
                a_we       = 1'b1;
                len_a_next = len_a + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            wsed_pkg::REQ_LOAD_SECOND: begin
              if (len_b < LEN_W'(MAX_WORDS)) begin
                b_we       = 1'b1;
                len_b_next = len_b + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            wsed_pkg::REQ_COMPUTE: begin
              if (len_a == '0 || len_b == '0) begin
                score_next = wsed_pkg::sat_dist(empty_w);
                state_next = wsed_pkg::ST_FINISH;
              end else begin
                row_i_next = LEN_W'(1);
                state_next = wsed_pkg::ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      wsed_pkg::ST_ROW: begin
        // Fetch row word and first column of the previous row
        a_re       = 1'b1;
        b_re       = 1'b1;
        c_re       = 1'b1;
        col_j_next = LEN_W'(1);
        left_next  = row_i;
        diag_next  = row_m1;
        state_next = wsed_pkg::ST_CELL;
      end
      wsed_pkg::ST_CELL: begin
        c_we      = 1'b1;
        left_next = cell_cost;
        diag_next = above;
        if (col_j == len_b) begin
          if (row_i == len_a) begin
            score_next = wsed_pkg::sat_dist(adj_w);
            state_next = wsed_pkg::ST_FINISH;
          end else begin
            row_i_next = row_i + 1'b1;
            state_next = wsed_pkg::ST_ROW;
          end
        end else begin
          col_j_next = col_j + 1'b1;
          b_re       = 1'b1;
          b_raddr    = col_j[AW-1:0];
          c_re       = 1'b1;
          c_raddr    = col_j + 1'b1;
        end
      end
      wsed_pkg::ST_FINISH: begin
        if (!res_valid || !res_stall) begin
          res_valid_next         = 1'b1;
          res_data_next.distance = score;
          res_data_next.overflow = dropped;
          len_a_next             = '0;
          len_b_next             = '0;
          dropped_next           = 1'b0;
          state_next             = wsed_pkg::ST_IDLE;
        end
      end
      default: state_next = wsed_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsed_pkg::ST_IDLE;
      len_a     <= '0;
      len_b     <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len_a     <= len_a_next;
      len_b     <= len_b_next;
      dropped   <= dropped_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    row_i    <= row_i_next;
    col_j    <= col_j_next;
    left     <= left_next;
    diag     <= diag_next;
    score    <= score_next;
    res_data <= res_data_next;
  end

endmodule

@@ sv/word_sequence_edit_distance_unit.sv @@
// Word-sequence edit distance unit.
// Request channel (req_valid / req_stall / req_data): each request either
// appends one word code to the first or second sequence, or asks for the
// result. Only the low TOKEN_BITS bits of a code are stored and compared.
// Request code 3 is accepted and discarded. Words past MAX_WORDS per
// sequence are dropped and reported through the overflow bit.
// Result channel (res_valid / res_stall / res_data): one result per compute
// request: Levenshtein distance minus both lengths, or the other length when
// one sequence is empty, saturated to 8 bits. Lengths and the overflow flag
// clear once the result is issued.
// Throughput: the back end handles a load in ST_IDLE, so loads stream at one
// per cycle while no compute is running. A compute runs ST_ROW to fetch each
// row's words and first cost, then ST_CELL for each cell on the single cell
// datapath walking the cost row in RAM, one cell per cycle, then ST_FINISH
// issues the result; an empty sequence goes straight to ST_FINISH.
// The request queue holds 2 entries; req_stall rises when full.
// Reset (rst, synchronous) empties the queue, zeroes both lengths and the
// flag; no memory clearing pass is needed. A stalled result holds in the
// output register; the back end waits at the end of the next compute.
module word_sequence_edit_distance_unit #(
  parameter int MAX_WORDS  = wsed_pkg::MAX_WORDS_DEF,
  parameter int TOKEN_BITS = wsed_pkg::TOKEN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  wsed_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output wsed_pkg::res_t res_data
);

  wsed_pkg::work_chan_t chan;
  logic                 pop;

  // Front end: classify, filter unused codes, queue
  wsed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .chan      (chan),
    .pop       (pop)
  );

  // Back end: word stores, DP sequencer, result register
  wsed_back #(
    .MAX_WORDS  (MAX_WORDS),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .chan      (chan),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

@@ tb/sv/word_sequence_edit_distance_unit_tb.sv @@
`timescale 1ns / 100ps

module word_sequence_edit_distance_unit_tb;

  localparam int SEQ_DEPTH = wsed_pkg::MAX_WORDS_DEF;
  // Only the low TOKEN_BITS bits of a word code are kept and compared
  localparam logic [wsed_pkg::TOKEN_W-1:0] TOKEN_MASK =
    {wsed_pkg::TOKEN_W{1'b1}} >> (wsed_pkg::TOKEN_W - wsed_pkg::TOKEN_BITS_DEF);
  // Request code with no meaning; the block must swallow it silently
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SCRATCH_WORDS = 80;

  // Every input has a known value from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic res_stall = 1'b0;
  wsed_pkg::req_t req_data = '0;
  logic req_stall;
  logic res_valid;
  wsed_pkg::res_t res_data;

  // Traffic shaping, set per test
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  int requests_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Scores still owed by the block, oldest first
  wsed_pkg::res_t pending_scores[$];

  // Shadow copy of the block's word stores and counters
  logic [wsed_pkg::TOKEN_W-1:0] stored_first[SEQ_DEPTH];
  logic [wsed_pkg::TOKEN_W-1:0] stored_second[SEQ_DEPTH];
  int first_count = 0;
  int second_count = 0;
  logic words_dropped = 1'b0;

  // Word lists that the tests build before sending a pair
  logic [wsed_pkg::TOKEN_W-1:0] words_a[SCRATCH_WORDS];
  logic [wsed_pkg::TOKEN_W-1:0] words_b[SCRATCH_WORDS];
  logic [wsed_pkg::TOKEN_W-1:0] vocab[6];
  int vocab_size = 1;

  always #5 clk = ~clk;

  word_sequence_edit_distance_unit uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  // Unit-cost Levenshtein over the shadow stores with a single rolling row,
  // then minus both lengths. An empty side gives the other length as is.
  function automatic logic signed [wsed_pkg::DIST_W-1:0] edit_score();
    int row[SEQ_DEPTH+1];
    int diag, above, cost, i, j, raw;
    if (first_count == 0) begin
      raw = second_count;
    end else if (second_count == 0) begin
      raw = first_count;
    end else begin
      for (j = 0; j <= second_count; j++) row[j] = j;
      for (i = 1; i <= first_count; i++) begin
        diag = row[0];
        row[0] = i;
        for (j = 1; j <= second_count; j++) begin
          above = row[j];
          cost = diag + ((stored_first[i-1] == stored_second[j-1]) ? 0 : 1);
          if (above + 1 < cost) cost = above + 1;
          if (row[j-1] + 1 < cost) cost = row[j-1] + 1;
          row[j] = cost;
          diag = above;
        end
      end
      raw = row[second_count] - first_count - second_count;
    end
    // Saturate to the 8-bit result field
    if (raw > 127) raw = 127;
    else if (raw < -128) raw = -128;
    return raw[wsed_pkg::DIST_W-1:0];
  endfunction

  // Apply one accepted request to the shadow state; a compute owes a score
  function automatic void track_request(wsed_pkg::req_t r);
    wsed_pkg::res_t score;
    case (r.req_type)
      wsed_pkg::REQ_LOAD_FIRST: begin
        if (first_count < SEQ_DEPTH) begin
          stored_first[first_count] = r.token & TOKEN_MASK;
          first_count++;
        end else begin
          words_dropped = 1'b1;
        end
      end
      wsed_pkg::REQ_LOAD_SECOND: begin
        if (second_count < SEQ_DEPTH) begin
          stored_second[second_count] = r.token & TOKEN_MASK;
          second_count++;
        end else begin
          words_dropped = 1'b1;
        end
      end
      wsed_pkg::REQ_COMPUTE: begin
        score.distance = edit_score();
        score.overflow = words_dropped;
        pending_scores = {pending_scores, score};
        first_count = 0;
        second_count = 0;
        words_dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic wsed_pkg::req_t make_req(logic [1:0] op,
                                              logic [wsed_pkg::TOKEN_W-1:0] tok);
    wsed_pkg::req_t r;
    r.req_type = op;
    r.token = tok;
    return r;
  endfunction

  // Mostly words from a tiny vocabulary so that matches are common
  function automatic logic [wsed_pkg::TOKEN_W-1:0] pick_word();
    if ($urandom_range(99) < 80) return vocab[$urandom_range(vocab_size - 1)];
    return $urandom();
  endfunction

  // Mostly short sequences; long ones are slow
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(25, SEQ_DEPTH);
    if (r < 15) return $urandom_range(9, 24);
    return $urandom_range(0, 8);
  endfunction

  task automatic refresh_vocab();
    vocab_size = $urandom_range(1, 6);
    foreach (vocab[k]) vocab[k] = $urandom();
  endtask

  // Second list partly copies the first so edit distances stay interesting
  task automatic fill_random_pair(int na, int nb);
    refresh_vocab();
    for (int i = 0; i < na; i++) words_a[i] = pick_word();
    for (int j = 0; j < nb; j++) begin
      if (j < na && $urandom_range(99) < 60) words_b[j] = words_a[j];
      else words_b[j] = pick_word();
    end
  endtask

  // Offer one request and hold it until accepted. Idle gaps are decided
  // before valid rises, so valid never reacts to stall.
  task automatic send_request(wsed_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    track_request(r);
    if (r.req_type != REQ_UNUSED) requests_sent++;
  endtask

  // Loads of words_a / words_b in random interleaving, then a compute.
  // noise_pct sprinkles unused request codes between loads.
  task automatic send_word_pair(int na, int nb, int noise_pct);
    int i, j;
    logic pick_first;
    i = 0;
    j = 0;
    while (i < na || j < nb) begin
      if ($urandom_range(99) < noise_pct) send_request(make_req(REQ_UNUSED, $urandom()));
      pick_first = (j >= nb) || (i < na && $urandom_range(1) == 1);
      if (pick_first) begin
        send_request(make_req(wsed_pkg::REQ_LOAD_FIRST, words_a[i]));
        i++;
      end else begin
        send_request(make_req(wsed_pkg::REQ_LOAD_SECOND, words_b[j]));
        j++;
      end
    end
    // token is don't-care on compute, so randomize it
    send_request(make_req(wsed_pkg::REQ_COMPUTE, $urandom()));
  endtask

  // Drop valid and wait for every owed score. Always waits on the clock before
  // checking, so that valid is never lowered and raised within one step.
  task automatic wait_for_scores();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
  endtask

  // Empty sides: both empty gives 0, one empty gives the other length
  task automatic test_empty_sequences();
    send_idle_pct = 0;
    stall_pct = 0;
    send_word_pair(0, 0, 0);
    fill_random_pair(0, 3);
    send_word_pair(0, 3, 0);
    fill_random_pair(2, 0);
    send_word_pair(2, 0, 0);
    wait_for_scores();
  endtask

  // All-zero, all-one and alternating codes; the last pair differs in bit 31 only
  task automatic test_token_extremes();
    words_a[0] = '0;
    words_a[1] = '1;
    words_a[2] = 32'hAAAA_AAAA;
    words_a[3] = 32'h8000_0000;
    words_b[0] = '0;
    words_b[1] = '1;
    words_b[2] = 32'h5555_5555;
    words_b[3] = 32'h0000_0001;
    send_word_pair(4, 4, 0);
    words_a[0] = '1;
    words_b[0] = '1;
    send_word_pair(1, 1, 0);
    words_a[0] = 32'h0000_0001;
    words_b[0] = 32'h8000_0001;
    send_word_pair(1, 1, 0);
    wait_for_scores();
  endtask

  // Code 3 alone and mixed into a pair must leave no trace
  task automatic test_unused_code();
    send_request(make_req(REQ_UNUSED, '1));
    send_request(make_req(REQ_UNUSED, '0));
    fill_random_pair(3, 2);
    send_word_pair(3, 2, 50);
    wait_for_scores();
  endtask

  // Full stores: extra words dropped, overflow raised, then cleared.
  // 66 vs identical 64 gives the most negative score; 0 vs 65 the largest.
  task automatic test_full_store();
    refresh_vocab();
    for (int i = 0; i < SEQ_DEPTH + 2; i++) words_a[i] = pick_word();
    for (int j = 0; j < SEQ_DEPTH; j++) words_b[j] = words_a[j];
    send_word_pair(SEQ_DEPTH + 2, SEQ_DEPTH, 0);
    fill_random_pair(0, SEQ_DEPTH + 1);
    send_word_pair(0, SEQ_DEPTH + 1, 0);
    fill_random_pair(SEQ_DEPTH, 1);
    send_word_pair(SEQ_DEPTH, 1, 0);
    wait_for_scores();
  endtask

  // Receiver holds off while the sender keeps pushing computes, so the
  // output register and request queue fill and req_stall must rise.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    repeat (8) begin
      fill_random_pair(2, 2);
      send_word_pair(2, 2, 0);
    end
    // sender pauses here until every score is back
    wait_for_scores();
  endtask

  // Random pairs: mostly well formed, some empty sides, rare overflow
  task automatic run_random_phase(int idle, int stall, int budget);
    int stop_at, na, nb;
    send_idle_pct = idle;
    stall_pct = stall;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      na = pick_length();
      nb = ($urandom_range(99) < 40) ? na : pick_length();
      if ($urandom_range(99) < 2) begin
        if ($urandom_range(1) == 1) na = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 6);
        else nb = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 6);
      end
      fill_random_pair(na, nb);
      send_word_pair(na, nb, 3);
    end
    wait_for_scores();
  endtask

  // Result side: random stall, or a counted hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Score checker: each accepted result against the oldest owed score
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_scores.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: distance %0d overflow %0b",
                   $signed(res_data.distance), res_data.overflow);
      end else begin
        if (res_data.distance !== pending_scores[0].distance ||
            res_data.overflow !== pending_scores[0].overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected distance %0d overflow %0b, got distance %0d overflow %0b",
                     $signed(pending_scores[0].distance), pending_scores[0].overflow,
                     $signed(res_data.distance), res_data.overflow);
        end
        void'(pending_scores.pop_front());
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("word_sequence_edit_distance_unit test failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_sequences();
    test_token_extremes();
    test_unused_code();
    test_full_store();
    test_backpressure();

    // no idling, then sender gaps, receiver stalls, and both
    run_random_phase(0, 0, 250);
    run_random_phase(55, 0, 250);
    run_random_phase(0, 55, 250);
    run_random_phase(32, 32, 250);

    // settle: nothing owed, let the back end go quiet
    stall_pct = 0;
    wait_for_scores();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("word_sequence_edit_distance_unit test passed");
    end else begin
      $display("word_sequence_edit_distance_unit test failed");
    end
    $finish;
  end

endmodule
